[rtl/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the signed decimal field formatter
// Holds the controller states, the command and status bundles between the
// controller and the datapath, register indexes and character codes.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Widths of the stream payloads.
  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 8;

  // Longest field in characters, and the digit count of a 64-bit magnitude.
  localparam int MAX_CHARS  = 64;
  localparam int NUM_DIGITS = 20;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FIELD_WIDTH  = 3'd0,
    REG_MIN_DIGITS   = 3'd1,
    REG_LEFT_JUSTIFY = 3'd2,
    REG_FORCE_SIGN   = 3'd3,
    REG_SPACE_SIGN   = 3'd4
  } cfg_reg_t;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new value
    logic conv_step;  // one shift-add-3 step
    logic size;       // compute field layout
    logic emit;       // load the next character into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;  // this conversion step is the final one
    logic out_free;   // output register can take a word this cycle
    logic emit_last;  // the character at the current position ends the field
  } sts_t;

endpackage

[rtl/sdf_ctrl.sv]
// ----------------------------------------------------------------------------
// sdf_ctrl: sequencing controller of the signed decimal field formatter
// Steps each value through capture, binary to decimal conversion, layout
// and character output, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module sdf_ctrl
  import sdf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_last) state_next = ST_SIZE;
      end
      ST_SIZE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.emit_last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
      end
      ST_SIZE: begin
        cmd.size = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/sdf_dpath.sv]
// ----------------------------------------------------------------------------
// sdf_dpath: datapath of the signed decimal field formatter
// Holds the configuration registers, a shift-add-3 binary to BCD converter,
// the field layout registers and the registered character output.
// ----------------------------------------------------------------------------
module sdf_dpath
  import sdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [VALUE_W-1:0]    in_value,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char,
  output logic                  out_last
);

  // Configuration registers.
  logic [6:0] field_width;
  logic [5:0] min_digits;
  logic       left_justify;
  logic       force_sign;
  logic       space_sign;

  // Conversion state.
  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic [3:0]         bcd      [NUM_DIGITS];
  logic [3:0]         bcd_adj  [NUM_DIGITS];
  logic [3:0]         bcd_next [NUM_DIGITS];
  logic [5:0]         bit_cnt;

  // Layout registers.
  logic              has_sign;
  logic [CHAR_W-1:0] sign_char;
  logic [5:0]        nd;
  logic [6:0]        blen;
  logic [6:0]        pad;
  logic [6:0]        total;
  logic [5:0]        pos;

  // Layout calculation.
  logic [4:0] ndig;
  logic [5:0] nd_calc;
  logic       sign_on;
  logic [6:0] blen_calc;
  logic [6:0] width_clamp;
  logic [6:0] total_calc;

  // Character selection.
  logic [6:0]        pos_w;
  logic              in_body;
  logic [6:0]        body_idx;
  logic [6:0]        digit_off;
  logic [5:0]        digit_idx;
  logic [3:0]        digit_sel;
  logic [CHAR_W-1:0] char_calc;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_width  <= 7'd0;
      min_digits   <= 6'd1;
      left_justify <= 1'b0;
      force_sign   <= 1'b0;
      space_sign   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FIELD_WIDTH:  field_width  <= cfg_data;
        REG_MIN_DIGITS:   min_digits   <= cfg_data[5:0];
        REG_LEFT_JUSTIFY: left_justify <= cfg_data[0];
        REG_FORCE_SIGN:   force_sign   <= cfg_data[0];
        REG_SPACE_SIGN:   space_sign   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Shift-add-3 step: correct every digit, then shift one magnitude bit in.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    bcd_next[0] = {bcd_adj[0][2:0], mag[VALUE_W-1]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      bcd_next[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
    end
  end

  // Conversion registers. The most negative value negates to itself, which
  // read as unsigned is the right magnitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= 6'd0;
    end else if (cmd.load) begin
      bit_cnt <= 6'd0;
    end else if (cmd.conv_step) begin
      bit_cnt <= bit_cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= in_value[VALUE_W-1];
      mag <= in_value[VALUE_W-1] ? (~in_value + 64'd1) : in_value;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd[i] <= 4'd0;
      end
    end else if (cmd.conv_step) begin
      mag <= {mag[VALUE_W-2:0], 1'b0};
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd[i] <= bcd_next[i];
      end
    end
  end

  // Field layout: significant digits, zero fill, sign and space padding.
  always_comb begin
    ndig = 5'd1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) ndig = 5'(i + 1);
    end
    nd_calc     = (min_digits > {1'b0, ndig}) ? min_digits : {1'b0, ndig};
    sign_on     = neg | force_sign | space_sign;
    blen_calc   = {1'b0, nd_calc} + {6'd0, sign_on};
    width_clamp = (field_width > 7'(MAX_CHARS)) ? 7'(MAX_CHARS) : field_width;
    total_calc  = (blen_calc > width_clamp) ? blen_calc : width_clamp;
  end

  always_ff @(posedge clk) begin
    if (cmd.size) begin
      has_sign  <= sign_on;
      sign_char <= neg ? CHAR_MINUS : (force_sign ? CHAR_PLUS : CHAR_SPACE);
      nd        <= nd_calc;
      blen      <= blen_calc;
      pad       <= total_calc - blen_calc;
      total     <= total_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 6'd0;
    end else if (cmd.size) begin
      pos <= 6'd0;
    end else if (cmd.emit) begin
      pos <= pos + 6'd1;
    end
  end

  // Character at the current position.
  always_comb begin
    pos_w = {1'b0, pos};
    if (left_justify) begin
      in_body  = pos_w < blen;
      body_idx = pos_w;
    end else begin
      in_body  = pos_w >= pad;
      body_idx = pos_w - pad;
    end
    digit_off = body_idx - {6'd0, has_sign};
    digit_idx = nd - 6'd1 - digit_off[5:0];
    digit_sel = (digit_idx < 6'(NUM_DIGITS)) ? bcd[digit_idx[4:0]] : 4'd0;
    if (!in_body) begin
      char_calc = CHAR_SPACE;
    end else if (has_sign && body_idx == 7'd0) begin
      char_calc = sign_char;
    end else begin
      char_calc = CHAR_ZERO + {4'd0, digit_sel};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= char_calc;
      out_last <= sts.emit_last;
    end
  end

  // Status.
  always_comb begin
    sts.conv_last = bit_cnt == 6'd63;
    sts.out_free  = !out_valid || out_ready;
    sts.emit_last = pos_w == (total - 7'd1);
  end

`ifndef ASSERT_OFF
  // A character is only loaded when the output register has room.
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("character loaded over a pending output word");

  // Layout starts only after exactly 64 conversion steps.
  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    cmd.size |-> $past(cmd.conv_step) && bit_cnt == 6'd0)
    else $error("layout started before conversion finished");

  // The output position never runs past the field.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> pos_w < total)
    else $error("character position beyond field length");

  // Every field is between one and the maximum number of characters.
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    cmd.size |=> (total != 7'd0 && total <= 7'(MAX_CHARS) && pad + blen == total))
    else $error("field layout out of range");
`endif

endmodule

[rtl/signed_decimal_field_formatter_unit.sv]
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_unit: printf-style signed decimal formatter
// Turns each signed 64-bit input word into its decimal text, one ASCII
// character per output word, with tlast on the final character.
// ----------------------------------------------------------------------------
// Each accepted value is converted to decimal by a shift-add-3 converter
// that takes one magnitude bit per cycle, over every bit of the magnitude.
// The layout is then fixed (sign, zero fill to min_digits, space padding
// to field_width, left or right justified), and the characters follow at
// one per cycle while m_axis_tready is high. The field length is 1 to 64
// characters. A new value is taken as soon as the last character of the
// previous one is in the output register. Configuration writes are
// applied at once and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter_unit
  import sdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,   // [63:0] value
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [CHAR_W-1:0]     m_axis_tdata,   // [7:0] char_code
  output logic                  m_axis_tlast    // last_char
);

  cmd_t cmd;
  sts_t sts;

  sdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdf_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_value  (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

[tb/sv/signed_decimal_field_formatter_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_unit_tb: self-checking bench of the formatter
// Feeds signed 64-bit values under many format settings. It predicts the
// character stream of each value and checks every output word and its tlast.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter_unit_tb;
  import sdf_pkg::*;

  // Register indexes past the end of the list; writes there must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_BASE = 3'd5;
  localparam int NUM_SPARE      = 3;

  localparam int NUM_DIR        = 23;
  localparam int NUM_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 3000;

  // One expected output word.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } fmt_char_t;

  // One directed case: format setting, value and, where obvious, the text.
  typedef struct {
    logic [6:0]         width;
    logic [5:0]         digits;
    bit                 left;
    bit                 plus;
    bit                 space;
    logic [VALUE_W-1:0] value;
    string              text;
  } fmt_case_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [VALUE_W-1:0]    s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [CHAR_W-1:0]     m_axis_tdata;
  logic                  m_axis_tlast;

  // Format setting as the block should currently hold it.
  logic [6:0] fmt_width;
  logic [5:0] fmt_digits;
  bit         fmt_left;
  bit         fmt_plus;
  bit         fmt_space;

  fmt_char_t  pending_chars[$];
  int         src_idle_pct;
  int         snk_stall_pct;
  bit         hold_req;
  int         quiet_cycles;
  int         errors;
  int         values_sent;
  int         chars_seen;
  int         settings_used;

  fmt_case_t dir_cases [NUM_DIR] = '{
    '{7'd0,   6'd0,  0, 0, 0, 64'd0,                   "0"},
    '{7'd0,   6'd1,  0, 0, 0, 64'd5,                   "5"},
    '{7'd0,   6'd1,  0, 0, 0, -64'sd1,                 "-1"},
    '{7'd0,   6'd1,  0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807"},
    '{7'd0,   6'd1,  0, 0, 0, 64'h8000_0000_0000_0000, "-9223372036854775808"},
    '{7'd0,   6'd0,  0, 0, 0, 64'd0,                   "0"},
    '{7'd0,   6'd1,  0, 1, 0, 64'd42,                  "+42"},
    '{7'd0,   6'd1,  0, 0, 1, 64'd42,                  " 42"},
    '{7'd0,   6'd1,  0, 1, 1, 64'd7,                   "+7"},
    '{7'd0,   6'd1,  0, 1, 1, -64'sd7,                 "-7"},
    '{7'd0,   6'd1,  0, 1, 0, 64'd0,                   "+0"},
    '{7'd8,   6'd1,  0, 0, 0, 64'd123,                 "     123"},
    '{7'd8,   6'd1,  1, 0, 0, -64'sd123,               "-123    "},
    '{7'd5,   6'd1,  0, 0, 1, 64'd12,                  "   12"},
    '{7'd0,   6'd5,  0, 0, 0, 64'd42,                  "00042"},
    '{7'd8,   6'd5,  0, 1, 0, 64'd42,                  "  +00042"},
    '{7'd3,   6'd0,  0, 0, 0, 64'd12345,               "12345"},
    '{7'd64,  6'd1,  0, 0, 0, 64'd1,                   ""},
    '{7'd127, 6'd1,  1, 0, 0, -64'sd5,                 ""},
    '{7'd0,   6'd63, 0, 1, 0, 64'h8000_0000_0000_0000, ""},
    '{7'd100, 6'd63, 0, 0, 1, 64'd0,                   ""},
    '{7'd100, 6'd63, 1, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, ""},
    '{7'd65,  6'd20, 1, 1, 0, 64'h0123_4567_89AB_CDEF, ""}
  };

  signed_decimal_field_formatter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Builds the expected characters of one value under the current setting.
  function automatic void predict_field(logic [VALUE_W-1:0] raw);
    logic [CHAR_W-1:0]  digs[$];
    logic [CHAR_W-1:0]  body[$];
    logic [VALUE_W-1:0] mag;
    int                 width;
    int                 pad;
    bit                 neg;
    neg = raw[VALUE_W-1];
    mag = neg ? -raw : raw;
    // Digits, most significant first; zero still yields one digit.
    do begin
      digs.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      body.push_back(CHAR_MINUS);
    end else if (fmt_plus) begin
      body.push_back(CHAR_PLUS);
    end else if (fmt_space) begin
      body.push_back(CHAR_SPACE);
    end
    for (int i = digs.size(); i < int'(fmt_digits); i++) body.push_back(CHAR_ZERO);
    foreach (digs[i]) body.push_back(digs[i]);
    // Widths beyond the longest field behave as the longest field.
    width = (int'(fmt_width) > MAX_CHARS) ? MAX_CHARS : int'(fmt_width);
    pad = (width > body.size()) ? width - body.size() : 0;
    if (!fmt_left) begin
      repeat (pad) pending_chars.push_back('{CHAR_SPACE, 1'b0});
    end
    foreach (body[i]) begin
      pending_chars.push_back('{body[i], (!fmt_left || pad == 0) && i == body.size() - 1});
    end
    if (fmt_left) begin
      for (int i = 0; i < pad; i++) pending_chars.push_back('{CHAR_SPACE, i == pad - 1});
    end
  endfunction

  // Picks a value: raw bits, short numbers, a given digit count or a boundary.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] tens;
    int                 kind;
    kind = $urandom_range(9);
    tens = 1;
    repeat ($urandom_range(19)) tens = tens * 10;
    case (kind)
      0, 1: return {$urandom, $urandom};
      2, 3: mag = $urandom_range(999);
      4, 5, 6: mag = {$urandom, $urandom} % tens;
      7: mag = tens - $urandom_range(1);
      8: return $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
      default: mag = $urandom_range(1);
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // One register write; the local copy follows the same masking.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(negedge clk);
    case (addr)
      REG_FIELD_WIDTH:  fmt_width  = data;
      REG_MIN_DIGITS:   fmt_digits = data[5:0];
      REG_LEFT_JUSTIFY: fmt_left   = data[0];
      REG_FORCE_SIGN:   fmt_plus   = data[0];
      REG_SPACE_SIGN:   fmt_space  = data[0];
      default: ;
    endcase
  endtask

  // Loads a full format setting; unused data bits carry random noise.
  task automatic apply_format(logic [6:0] width, logic [5:0] digits, bit left, bit plus,
                              bit space);
    write_reg(REG_FIELD_WIDTH, width);
    write_reg(REG_MIN_DIGITS, {1'($urandom), digits});
    write_reg(REG_LEFT_JUSTIFY, {6'($urandom), left});
    write_reg(REG_FORCE_SIGN, {6'($urandom), plus});
    write_reg(REG_SPACE_SIGN, {6'($urandom), space});
    write_reg(REG_SPARE_BASE + CFG_ADDR_W'($urandom_range(NUM_SPARE - 1)),
              CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offers one value, with optional idle cycles first. An empty text means
  // the expected characters come from the predictor.
  task automatic send_value(logic [VALUE_W-1:0] value, string text);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    if (text.len() == 0) begin
      predict_field(value);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        pending_chars.push_back('{text[i], i == text.len() - 1});
      end
    end
    values_sent++;
    @(negedge clk);
  endtask

  // Waits for every expected word, then lets the block settle.
  task automatic wait_drained();
    wait (pending_chars.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Output ready, with random stalls and an occasional long hold-off.
  initial begin
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Output checker and watchdog.
  always @(posedge clk) begin
    fmt_char_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        chars_seen++;
        if (pending_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, actual code %h last %b", $time, m_axis_tdata,
                   m_axis_tlast);
        end else begin
          want = pending_chars.pop_front();
          if (m_axis_tdata !== want.code || m_axis_tlast !== want.last) begin
            errors++;
            $display("%0t: expected code %h last %b, actual code %h last %b", $time,
                     want.code, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end else if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: timeout, no word accepted for %0d cycles", $time, quiet_cycles);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Stimulus: reset, directed cases, then random phases.
  initial begin
    logic [6:0] width;
    logic [5:0] digits;
    int         mode;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    errors        = 0;
    values_sent   = 0;
    chars_seen    = 0;
    settings_used = 0;
    fmt_width     = 7'd0;
    fmt_digits    = 6'd1;
    fmt_left      = 1'b0;
    fmt_plus      = 1'b0;
    fmt_space     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed cases; the first one runs on the reset setting.
    for (int i = 0; i < NUM_DIR; i++) begin
      if (i > 0) begin
        apply_format(dir_cases[i].width, dir_cases[i].digits, dir_cases[i].left,
                     dir_cases[i].plus, dir_cases[i].space);
      end
      send_value(dir_cases[i].value, dir_cases[i].text);
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    // Random phases: each has its own setting and idle mix.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_format(7'd0, 6'd0, 1'b0, 1'b0, 1'b0);
        1: apply_format(7'd127, 6'd63, 1'b1, 1'b1, 1'b1);
        default: begin
          width  = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
          digits = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(4));
          apply_format(width, digits, 1'($urandom), 1'($urandom), 1'($urandom));
        end
      endcase
      mode = ph % 4;
      src_idle_pct  = (mode == 1) ? 57 : (mode == 3) ? 7 : 0;
      snk_stall_pct = (mode == 2) ? 57 : (mode == 3) ? 7 : 0;
      // Output held off while values keep coming, so the input must stall.
      if (ph == PRESSURE_PHASE) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_value(random_value(), "");
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    wait (pending_chars.size() == 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d values and %0d characters under %0d format settings,",
             values_sent, chars_seen, settings_used + 1);
    $display("with sender gaps, output stalls and one long output hold-off.");
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
